// ----- design/e8e9_stream_decoder_core_defines.svh -----
// Assertion macros used by the E8/E9 stream decoder core.
`ifndef E8E9_STREAM_DECODER_CORE_DEFINES_SVH
`define E8E9_STREAM_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define E8E9_ASSERT_NOW(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |-> (cond_b)) \
        else $error("e8e9 assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define E8E9_ASSERT_NEXT(label, cond_a, cond_b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond_a) |=> (cond_b)) \
        else $error("e8e9 assertion failed");

`endif

// ----- design/e8e9_pkg.sv -----
// Package with the types and constants of the E8/E9 stream decoder.
package e8e9_pkg;

    // Shifted window, entry 0 newest, entry 5 oldest.
    typedef logic [5:0][7:0] win_t;
    // Held bytes between items, entry 0 newest.
    typedef logic [4:0][7:0] hold_t;

    localparam logic [7:0]  XOR_KEY   = 8'hB0;
    localparam logic [7:0]  OP_CALL   = 8'hE8;
    localparam logic [7:0]  OP_JMP    = 8'hE9;
    localparam logic [7:0]  OP_ESC    = 8'h0F;
    localparam logic [7:0]  JCC_MASK  = 8'hF0;
    localparam logic [7:0]  JCC_HIGH  = 8'h80;
    localparam logic [7:0]  TOP_POS   = 8'h00;
    localparam logic [7:0]  TOP_NEG   = 8'hFF;

    localparam logic [2:0]  HOLD_BYTES = 3'd5;
    localparam logic [2:0]  MAX_WORDS  = 3'd6;
    localparam logic [31:0] POS_RESET  = 32'd6;

endpackage

// ----- design/e8e9_restore.sv -----
// Address restore unit: detects a call or jump in the window and undoes the rewrite.
module e8e9_restore #(
    parameter int unsigned BLOCK_BYTES = 65536
) (
    input  e8e9_pkg::win_t win,
    input  logic [31:0]    pos,
    input  logic [31:0]    off,
    output e8e9_pkg::win_t win_out
);

    localparam logic [31:0] BLOCK_MASK = ~(32'(BLOCK_BYTES) - 32'd1);

    logic        top_ok;
    logic        op_ok;
    logic        in_block;
    logic [31:0] pos_m1;
    logic [31:0] pos_m6;
    logic [31:0] abs_addr;
    logic [31:0] rel_addr;

    always_comb
    begin
        top_ok = (win[0] == e8e9_pkg::TOP_POS) || (win[0] == e8e9_pkg::TOP_NEG);
        op_ok  = (win[4] == e8e9_pkg::OP_CALL) || (win[4] == e8e9_pkg::OP_JMP) ||
                 ((win[5] == e8e9_pkg::OP_ESC) &&
                  ((win[4] & e8e9_pkg::JCC_MASK) == e8e9_pkg::JCC_HIGH));
        // The six bytes of the window must sit in one block.
        pos_m1   = pos - 32'd1;
        pos_m6   = pos - 32'd6;
        in_block = ((pos_m1 ^ pos_m6) & BLOCK_MASK) == 32'd0;

        abs_addr = {win[0], win[3] ^ e8e9_pkg::XOR_KEY, win[2] ^ e8e9_pkg::XOR_KEY,
                    win[1] ^ e8e9_pkg::XOR_KEY};
        // off already holds position plus segment base.
        rel_addr = abs_addr - off;
        rel_addr[31:25] = {7{rel_addr[24]}};

        win_out = win;
        if (top_ok && op_ok && in_block)
        begin
            win_out[3] = rel_addr[7:0];
            win_out[2] = rel_addr[15:8];
            win_out[1] = rel_addr[23:16];
            win_out[0] = rel_addr[31:24];
        end
    end

endmodule

// ----- design/e8e9_stream_decoder_core.sv -----
// Top level of the E8/E9 stream decoder: window, counters and output word buffer.
//
//   Channel   Signals                               Payload
//   input     s_axis_tvalid/tready/tdata/tlast      data_byte, end_of_segment
//   output    m_axis_tvalid/tready/tdata/tlast      out_byte, out_last
//   config    cfg_wr_en, cfg_wr_data                segment_base
//
// One input word is taken per cycle unless the output stalls. A fill byte yields no output
// word and a steady-state byte yields one, so a segment streams at one word per cycle.
// The final byte of a segment yields up to six words from the output buffer;
// the next input word waits until that buffer drains down to its last word.
// Reset (rst_n, asynchronous, active low) empties the buffer and resets the counters.
// A stall on the output side holds the buffered words and blocks new input.
`include "e8e9_stream_decoder_core_defines.svh"

module e8e9_stream_decoder_core #(
    parameter int unsigned BLOCK_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tlast,    // end_of_segment

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
    output logic        m_axis_tlast,    // out_last

    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data      // segment_base
);

    // Segment state. off_reg tracks position_reg plus base_reg so that the
    // restore path needs only one subtraction.
    e8e9_pkg::hold_t win_reg,  win_next;
    logic [2:0]      fill_reg, fill_next;
    logic [31:0]     position_reg, position_next;
    logic [31:0]     off_reg, off_next;
    logic [31:0]     base_reg, base_next;

    // Output buffer: entry 0 is the word on the master side.
    logic [5:0][7:0] pend_reg, pend_next;
    logic [2:0]      pend_cnt_reg, pend_cnt_next;
    logic            pend_last_reg, pend_last_next;

    e8e9_pkg::win_t  shifted;
    e8e9_pkg::win_t  restored;
    logic            s_accept;
    logic            m_accept;
    logic            fill_done;
    logic [2:0]      src_idx;

    assign m_axis_tvalid = pend_cnt_reg != 3'd0;
    assign m_axis_tdata  = pend_reg[0];
    assign m_axis_tlast  = pend_last_reg && (pend_cnt_reg == 3'd1);
    // Accept when the buffer will be empty after this edge.
    assign s_axis_tready = (pend_cnt_reg == 3'd0) ||
                           ((pend_cnt_reg == 3'd1) && m_axis_tready);

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign m_accept  = m_axis_tvalid && m_axis_tready;
    assign fill_done = fill_reg == e8e9_pkg::HOLD_BYTES;

    always_comb
    begin
        shifted[0] = s_axis_tdata;
        for (int i = 1; i < 6; i++)
        begin
            shifted[i] = win_reg[i - 1];
        end
    end

    e8e9_restore #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_restore (
        .win     (shifted),
        .pos     (position_reg),
        .off     (off_reg),
        .win_out (restored)
    );

    always_comb
    begin
        win_next       = win_reg;
        fill_next      = fill_reg;
        position_next  = position_reg;
        off_next       = off_reg;
        base_next      = base_reg;
        pend_next      = pend_reg;
        pend_cnt_next  = pend_cnt_reg;
        pend_last_next = pend_last_reg;
        src_idx        = 3'd0;

        // Drain one word; the buffer shifts toward entry 0.
        if (m_accept)
        begin
            for (int k = 0; k < 5; k++)
            begin
                pend_next[k] = pend_reg[k + 1];
            end
            pend_cnt_next = pend_cnt_reg - 3'd1;
        end

        if (s_accept)
        begin
            pend_last_next = s_axis_tlast;
            if (!fill_done)
            begin
                if (s_axis_tlast)
                begin
                    // Short segment: held bytes oldest first, then the new byte.
                    for (int k = 0; k < 6; k++)
                    begin
                        src_idx = 3'(fill_reg - 3'd1 - 3'(k));
                        if (3'(k) < fill_reg)
                        begin
                            pend_next[k] = win_reg[src_idx];
                        end
                        else if (3'(k) == fill_reg)
                        begin
                            pend_next[k] = s_axis_tdata;
                        end
                    end
                    pend_cnt_next = fill_reg + 3'd1;
                    fill_next     = 3'd0;
                end
                else
                begin
                    win_next      = shifted[4:0];
                    fill_next     = fill_reg + 3'd1;
                    pend_cnt_next = 3'd0;
                end
            end
            else
            begin
                // Steady state: emit the oldest byte; on the final byte also
                // flush the five remaining bytes unchanged.
                pend_next[0] = shifted[5];
                pend_next[1] = shifted[4];
                pend_next[2] = restored[3];
                pend_next[3] = restored[2];
                pend_next[4] = restored[1];
                pend_next[5] = restored[0];
                win_next     = {shifted[4], restored[3], restored[2], restored[1],
                                restored[0]};
                if (s_axis_tlast)
                begin
                    pend_cnt_next = e8e9_pkg::MAX_WORDS;
                    fill_next     = 3'd0;
                    position_next = e8e9_pkg::POS_RESET;
                    off_next      = e8e9_pkg::POS_RESET + base_reg;
                end
                else
                begin
                    pend_cnt_next = 3'd1;
                    position_next = position_reg + 32'd1;
                    off_next      = off_reg + 32'd1;
                end
            end
        end

        // The user must write only while the block is idle; the block itself does not enforce it.
        if (cfg_wr_en)
        begin
            base_next = cfg_wr_data;
            off_next  = position_reg + cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= 3'd0;
            position_reg  <= e8e9_pkg::POS_RESET;
            off_reg       <= e8e9_pkg::POS_RESET;
            base_reg      <= 32'd0;
            pend_cnt_reg  <= 3'd0;
            pend_last_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            position_reg  <= position_next;
            off_reg       <= off_next;
            base_reg      <= base_next;
            pend_cnt_reg  <= pend_cnt_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        pend_reg <= pend_next;
    end

    `E8E9_ASSERT_NOW(a_pend_bound, 1'b1, pend_cnt_reg <= e8e9_pkg::MAX_WORDS)
    `E8E9_ASSERT_NOW(a_off_tracks, 1'b1, off_reg == position_reg + base_reg)
    `E8E9_ASSERT_NEXT(a_fill_silent, s_accept && !fill_done && !s_axis_tlast, pend_cnt_reg == 3'd0)
    `E8E9_ASSERT_NEXT(a_seg_clear, s_accept && s_axis_tlast, (fill_reg == 3'd0) && (position_reg == e8e9_pkg::POS_RESET))

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the E8/E9 stream decoder core.
module tb;

    // The block size the decoder is built with here.
    localparam int unsigned BLOCK_SIZE = 256;
    // Cycles without any handshake before the run is declared hung.
    localparam int STALL_LIMIT = 5000;
    // Quiet cycles after the last word, before a register write and at the end.
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_WORDS_PER_PHASE = 20;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } out_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;    // end_of_segment
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [7:0] out_byte
    logic        m_axis_tlast;           // out_last
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = 32'h0;    // segment_base

    // Decoder state as the testbench predicts it.
    e8e9_pkg::win_t dec_window;
    logic [31:0]    dec_position;
    int             dec_held;
    logic [31:0]    dec_base;

    // Restored words still owed by the block, oldest first.
    out_word_t   restored_words[$];
    out_word_t   next_restored;

    int          mismatch_count = 0;
    int          stall_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    e8e9_stream_decoder_core #(
        .BLOCK_BYTES(BLOCK_SIZE)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Returns the decoder to its start-of-segment state. The base register
    // is not part of the segment state and keeps its value.
    function automatic void clear_segment_state();
        dec_window   = '0;
        dec_position = e8e9_pkg::POS_RESET;
        dec_held     = 0;
    endfunction

    function automatic void push_restored(logic [7:0] data, logic last);
        out_word_t w;
        w.data = data;
        w.last = last;
        restored_words.push_back(w);
    endfunction

    // Undoes the absolute-address rewrite when the window holds a call,
    // a jump or a conditional near jump whose top address byte is a plain
    // sign extension, and the six bytes sit inside one block.
    function automatic void undo_address_rewrite();
        logic        top_ok;
        logic        opcode_ok;
        logic        same_block;
        logic [31:0] block_mask;
        logic [31:0] addr;
        top_ok = (dec_window[0] == e8e9_pkg::TOP_POS) ||
                 (dec_window[0] == e8e9_pkg::TOP_NEG);
        opcode_ok = (dec_window[4] == e8e9_pkg::OP_CALL) ||
                    (dec_window[4] == e8e9_pkg::OP_JMP) ||
                    ((dec_window[5] == e8e9_pkg::OP_ESC) &&
                     ((dec_window[4] & e8e9_pkg::JCC_MASK) == e8e9_pkg::JCC_HIGH));
        block_mask = 32'd0 - 32'(BLOCK_SIZE);
        same_block = (((dec_position - 32'd1) ^ (dec_position - 32'd6)) & block_mask) == 32'd0;
        if (!(top_ok && opcode_ok && same_block))
            return;
        addr = {dec_window[0], dec_window[3] ^ e8e9_pkg::XOR_KEY,
                dec_window[2] ^ e8e9_pkg::XOR_KEY, dec_window[1] ^ e8e9_pkg::XOR_KEY};
        addr = addr - dec_position - dec_base;
        // The relative target is a 25-bit signed value.
        addr[31:25] = {7{addr[24]}};
        dec_window[3] = addr[7:0];
        dec_window[2] = addr[15:8];
        dec_window[1] = addr[23:16];
        dec_window[0] = addr[31:24];
    endfunction

    // Advances the predicted decoder by one accepted input word and queues
    // every output word that it causes.
    function automatic void predict_decode(logic [7:0] data, logic last);
        if (dec_held < int'(e8e9_pkg::HOLD_BYTES))
        begin
            if (last)
            begin
                // Short segment: everything held goes out untouched.
                for (int i = dec_held - 1; i >= 0; i--)
                    push_restored(dec_window[i], 1'b0);
                push_restored(data, 1'b1);
                clear_segment_state();
                return;
            end
            dec_window = {dec_window[4:0], data};
            dec_held++;
            return;
        end
        dec_window = {dec_window[4:0], data};
        undo_address_rewrite();
        push_restored(dec_window[5], 1'b0);
        dec_position = dec_position + 32'd1;
        if (last)
        begin
            // The five bytes still held are flushed unchanged.
            for (int i = 4; i >= 0; i--)
                push_restored(dec_window[i], i == 0);
            clear_segment_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking, receiver stalls and the watchdog
    // ------------------------------------------------------------------

    // Every output word is compared with the oldest one still owed. All
    // signals are sampled at the edge before any nonblocking update lands.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (restored_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("tb: output word %h last %b with none owed",
                             m_axis_tdata, m_axis_tlast);
            end
            else
            begin
                next_restored = restored_words.pop_front();
                if (m_axis_tdata !== next_restored.data || m_axis_tlast !== next_restored.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("tb: mismatch: expected %h last %b, got %h last %b",
                                 next_restored.data, next_restored.last,
                                 m_axis_tdata, m_axis_tlast);
                end
            end
        end
    end

    // The receiver holds off at random according to the current pressure.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Counts cycles in which no word moves on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one input word, with random sender gaps beforehand, and
    // returns at the edge where it is accepted. Valid stays high so that
    // back-to-back words follow one another without a gap.
    task automatic send_word(logic [7:0] data, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_decode(data, last);
    endtask

    // Sends a whole segment, marking its final byte.
    task automatic send_segment(logic [7:0] seg[$]);
        foreach (seg[i])
            send_word(seg[i], i == seg.size() - 1);
    endtask

    // Lets every owed word drain, then waits for the block to go quiet.
    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (restored_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes the segment base while the block is idle.
    task automatic write_segment_base(logic [31:0] value);
        drain_outputs();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        dec_base = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Builds a random segment. Most bytes belong to call, jump or
    // conditional-jump sequences with a random address, a few of which have
    // a top byte that is not a sign extension; truncation at the segment
    // end leaves broken sequences too.
    function automatic void build_random_segment(ref logic [7:0] seg[$], input int len);
        logic [7:0] top;
        seg.delete();
        while (seg.size() < len)
        begin
            if ($urandom_range(3) != 0)
            begin
                case ($urandom_range(2))
                    0: seg.push_back(e8e9_pkg::OP_CALL);
                    1: seg.push_back(e8e9_pkg::OP_JMP);
                    default:
                    begin
                        seg.push_back(e8e9_pkg::OP_ESC);
                        seg.push_back(e8e9_pkg::JCC_HIGH | 8'($urandom_range(15)));
                    end
                endcase
                repeat (3) seg.push_back(8'($urandom_range(255)));
                if ($urandom_range(7) == 0)
                    top = 8'($urandom_range(255));
                else
                    top = $urandom_range(1) ? e8e9_pkg::TOP_NEG : e8e9_pkg::TOP_POS;
                seg.push_back(top);
            end
            else
                seg.push_back(8'($urandom_range(255)));
        end
        while (seg.size() > len)
            void'(seg.pop_back());
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Segments too short to fill the window, with the byte extremes, run
    // against the reset value of the base register.
    task automatic test_short_segments();
        send_segment('{8'hFF});
        send_segment('{8'h00, 8'hFF});
        send_segment('{e8e9_pkg::TOP_NEG, e8e9_pkg::OP_CALL, 8'h00, 8'h7F, 8'h80});
        drain_outputs();
    endtask

    // A call, a jump and a conditional near jump in one segment; the last
    // one completes on the final byte, just before the flush.
    task automatic test_opcode_restore();
        write_segment_base(32'hFFFF_FFFF);
        send_segment('{8'h90, e8e9_pkg::OP_CALL, 8'h11, 8'h22, 8'h33, e8e9_pkg::TOP_POS,
                       e8e9_pkg::OP_JMP, 8'h44, 8'h55, 8'h66, e8e9_pkg::TOP_NEG,
                       e8e9_pkg::OP_ESC, 8'h85, 8'hA7, 8'h88, 8'h99, e8e9_pkg::TOP_POS});
        write_segment_base(32'h0000_0000);
        send_segment('{8'h90, e8e9_pkg::OP_JMP, 8'hFF, 8'hFF, 8'hFF, e8e9_pkg::TOP_NEG,
                       8'hC3});
        drain_outputs();
    endtask

    // Random segments under one setting of sender and receiver pressure.
    task automatic test_random_traffic(int send_pct, int recv_pct);
        logic [7:0] seg[$];
        int         words_sent;
        int         len;
        write_segment_base($urandom());
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        words_sent = 0;
        while (words_sent < RANDOM_WORDS_PER_PHASE)
        begin
            // Now and then a segment too short to fill the window.
            len = ($urandom_range(5) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 16);
            build_random_segment(seg, len);
            send_segment(seg);
            words_sent += seg.size();
            // A quiet stretch between some segments keeps idle periods in the mix.
            if ($urandom_range(3) == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
        end
        drain_outputs();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_segment_state();
        dec_base = 32'h0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_segments();
        test_opcode_restore();
        test_random_traffic(8, 53);
        test_random_traffic(53, 8);
        test_random_traffic(0, 0);

        drain_outputs();
        if (mismatch_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/e8e9_pkg.sv
design/e8e9_restore.sv
design/e8e9_stream_decoder_core.sv
verif/tb.sv
